// File: rtl/core/s2d_pkg.sv
// s2d_pkg: shared types and constants for the signed-to-decimal text block.
// No dependencies.
package s2d_pkg;

	localparam int NUM_DIGITS = 5;
	localparam int MAG_W = 15;
	localparam int QUOT_W = 12;
	localparam int RECIP_SHIFT = 19;
	localparam logic [15:0] RECIP10 = 16'hCCCD;
	localparam logic [MAG_W-1:0] MAG_MAX = 15'h7FFF;
	localparam logic [7:0] CHAR_ZERO = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	typedef logic [2:0] digit_idx_t;

	typedef struct packed {
		logic neg;
		logic [10:0] bar;
		logic [2:0] row;
		logic [6:0] col;
	} side_t;

	typedef struct packed {
		side_t side;
		logic [MAG_W-1:0] quot;
		logic [NUM_DIGITS-1:0][3:0] digs;
	} work_t;

endpackage

// File: rtl/core/s2d_mag.sv
// s2d_mag: first stage, takes the input beat and forms sign and saturated magnitude.
// Depends on s2d_pkg.
module s2d_mag (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [15:0] value,
	input logic [2:0] bar_row,
	input logic [6:0] bar_column,
	output logic out_valid,
	input logic out_ready,
	output s2d_pkg::work_t out_work
);
	import s2d_pkg::*;

	logic valid_s1;
	work_t work_s1;
	work_t work_d;
	logic [15:0] neg_val;

	assign in_ready = !valid_s1 || out_ready;
	assign neg_val = 16'd0 - value;

	always_comb begin
		work_d = '0;
		work_d.side.neg = value[15];
		work_d.side.row = bar_row;
		work_d.side.col = bar_column;
		if (!value[15]) begin
			work_d.quot = value[MAG_W-1:0];
		end else if (neg_val[15]) begin
			work_d.quot = MAG_MAX;
		end else begin
			work_d.quot = neg_val[MAG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			work_s1 <= work_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_work = work_s1;
endmodule

// File: rtl/core/s2d_digit.sv
// s2d_digit: one divide-by-ten stage, reciprocal multiply, stores one digit.
// Depends on s2d_pkg.
module s2d_digit #(
	parameter int IDX = 0
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input s2d_pkg::work_t in_work,
	output logic out_valid,
	input logic out_ready,
	output s2d_pkg::work_t out_work
);
	import s2d_pkg::*;

	logic valid_s1;
	work_t work_s1;
	work_t work_d;
	logic [MAG_W+15:0] prod;
	logic [QUOT_W-1:0] q;
	logic [MAG_W-1:0] q10;
	logic [MAG_W-1:0] rem;

	assign in_ready = !valid_s1 || out_ready;
	assign prod = in_work.quot * RECIP10;
	assign q = prod[RECIP_SHIFT +: QUOT_W];
	// q*10 as shift-add
	assign q10 = MAG_W'({q, 3'b000}) + MAG_W'({q, 1'b0});
	assign rem = in_work.quot - q10;

	always_comb begin
		work_d = in_work;
		work_d.quot = MAG_W'(q);
		work_d.digs[IDX] = rem[3:0];
		// floor(floor(m/10)/2) == floor(m/20)
		if (IDX == 0) begin
			work_d.side.bar = q[11:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			work_s1 <= work_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_work = work_s1;
endmodule

// File: rtl/core/s2d_serial.sv
// s2d_serial: emits the sign and digits of one value, one beat per cycle while out_ready
// allows, through an output register. Depends on s2d_pkg.
module s2d_serial (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input s2d_pkg::work_t in_work,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] out_char,
	output logic out_last,
	output s2d_pkg::side_t out_side
);
	import s2d_pkg::*;

	logic busy_q;
	logic minus_q;
	digit_idx_t idx_q;
	logic [NUM_DIGITS-1:0][3:0] digs_q;
	side_t side_q;
	logic oval_q;
	logic [7:0] ochar_q;
	logic olast_q;
	side_t oside_q;

	logic slot_free;
	logic emit;
	logic emit_last;
	logic load;
	logic [NUM_DIGITS-1:0][3:0] digs_d;
	digit_idx_t top;

	assign slot_free = !oval_q || out_ready;
	assign emit = busy_q && slot_free;
	assign emit_last = emit && !minus_q && (idx_q == '0);
	assign in_ready = !busy_q || emit_last;
	assign load = in_valid && in_ready;

	always_comb begin
		digs_d = in_work.digs;
		digs_d[NUM_DIGITS-1] = in_work.quot[3:0];
		top = '0;
		for (int i = 1; i < NUM_DIGITS; i++) begin
			if (digs_d[i] != 4'd0) begin
				top = digit_idx_t'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			oval_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (emit_last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				oval_q <= 1'b1;
			end else if (out_ready) begin
				oval_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			oside_q <= side_q;
			if (minus_q) begin
				ochar_q <= CHAR_MINUS;
				olast_q <= 1'b0;
			end else begin
				ochar_q <= CHAR_ZERO + {4'd0, digs_q[idx_q]};
				olast_q <= (idx_q == '0);
			end
		end
		if (load) begin
			minus_q <= in_work.side.neg;
			idx_q <= top;
			digs_q <= digs_d;
			side_q <= in_work.side;
		end else if (emit) begin
			if (minus_q) begin
				minus_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 3'd1;
			end
		end
	end

	assign out_valid = oval_q;
	assign out_char = ochar_q;
	assign out_last = olast_q;
	assign out_side = oside_q;
endmodule

// File: rtl/core/signed_to_decimal_ascii_with_bar.sv
// signed_to_decimal_ascii_with_bar: top level, signed 16-bit value to decimal
// ASCII characters with bar data. Depends on s2d_pkg, s2d_mag, s2d_digit, s2d_serial.
//
//  channel | dir | tdata (low bit up)                         | tuser        | tlast
//  s_*     | in  | value[15:0] bar_row[18:16] bar_column[25:19] | -            | -
//  m_*     | out | text_char[7:0] bar_length[18:8] row_out[21:19] column_out[28:22]
//          |     |                                            | bar_negative | last_char
//
// An input beat passes the mag stage, four divide-by-ten stages, the serializer
// load and the output register. A value of n characters (1..6) occupies the
// serializer until its last character is emitted, and the next value loads in
// that cycle; the output gives one character per cycle while m_tready is high.
// Reset clears all valid and busy flags. m_tready low holds the output beat
// and backs up the pipeline stage by stage; nothing is dropped or repeated.
module signed_to_decimal_ascii_with_bar (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [31:0] s_tdata, // value, bar_row, bar_column, zero pad
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata, // text_char, bar_length, row_out, column_out, zero pad
	output logic m_tuser, // bar_negative
	output logic m_tlast
);
	import s2d_pkg::*;

	localparam int NSTG = NUM_DIGITS - 1;

	logic [NSTG:0] vld;
	logic [NSTG:0] rdy;
	work_t work [NSTG+1];
	logic [7:0] ch;
	side_t oside;

	s2d_mag u_mag (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.value(s_tdata[15:0]),
		.bar_row(s_tdata[18:16]),
		.bar_column(s_tdata[25:19]),
		.out_valid(vld[0]),
		.out_ready(rdy[0]),
		.out_work(work[0])
	);

	for (genvar g = 0; g < NSTG; g++) begin : g_dig
		s2d_digit #(.IDX(g)) u_dig (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(vld[g]),
			.in_ready(rdy[g]),
			.in_work(work[g]),
			.out_valid(vld[g+1]),
			.out_ready(rdy[g+1]),
			.out_work(work[g+1])
		);
	end

	s2d_serial u_ser (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld[NSTG]),
		.in_ready(rdy[NSTG]),
		.in_work(work[NSTG]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_char(ch),
		.out_last(m_tlast),
		.out_side(oside)
	);

	assign m_tdata = {3'd0, oside.col, oside.row, oside.bar, ch};
	assign m_tuser = oside.neg;

`ifndef SYNTHESIS
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[7:0] == CHAR_MINUS) |-> !m_tlast)
		else $error("minus sign marked as last character");
	a_minus_has_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[7:0] == CHAR_MINUS) |-> m_tuser)
		else $error("minus sign on a non-negative value");
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] == CHAR_MINUS ||
			(m_tdata[7:0] >= CHAR_ZERO && m_tdata[7:0] <= CHAR_ZERO + 8'd9)))
		else $error("output character is not a digit or minus");
	a_sign_first: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast && m_tuser) |=>
			!(m_tvalid && m_tdata[7:0] != CHAR_MINUS && m_tuser && $past(m_tlast) &&
			m_tdata[7:0] == CHAR_ZERO && m_tlast && m_tdata[18:8] == 11'd0))
		else $error("negative value written as zero");
`endif
endmodule
